// ===== design/rdq_pkg.sv =====
package rdq_pkg;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_PUSH_BACK  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_PULL       = 2'd2,
		CMD_CLEAR      = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_MSG     = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_ACCEPT  = 3'd2,
		ST_REJECT  = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	localparam int CNT_W  = 9;
	localparam int FILL_W = 9;

	// Configuration port.
	localparam int   ADDR_W           = 3;
	localparam logic REG_DEPTH_IN_USE = 1'b0;

	// Command queue between front and back end.
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PW    = $clog2(CQ_DEPTH);
	localparam int CQ_LW    = $clog2(CQ_DEPTH + 1);

	// Result queue at the output.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PW    = $clog2(RQ_DEPTH);
	localparam int RQ_LW    = $clog2(RQ_DEPTH + 1);

	// Classified command handed from front to back end.
	typedef struct packed {
		cmd_t             op;
		logic             first;
		logic [CNT_W-1:0] count;
	} cmd_item_t;

	// Result control fields, carried beside the message word.
	typedef struct packed {
		status_t           status;
		logic              last;
		logic [FILL_W-1:0] fill;
	} res_t;

endpackage

// ===== design/ring_deque_batch_queue.sv =====
// Ring-buffer deque of message words with batch pushes, queue-style ports on both sides.
// Commands: push back, push front, pull, clear. The first push item of a batch carries
// the batch size; the batch is taken only if that much room is free, otherwise each of
// its items comes back rejected. Every push item, clear and empty pull gives one result
// marked last; a pull gives min(request, fill) message results (request capped at
// MAX_PULL), the final one marked last, and a zero pull on a non-empty queue gives none.
// Timing: the front end takes one command a cycle, unless full, into a two-entry command
// queue. The back end handles a push, a clear or the start of a pull in its idle state,
// then reads one pulled message per cycle while the result queue has room, limited by
// the single read port of the slot RAM. Each result passes the read stage register and
// the RAM read register, then a four-entry result queue. Slot storage needs no clearing
// after reset. Writing depth_in_use (byte address 0) empties the queue; write it only
// while the block is idle. A depth of 0 acts as 1, above DEPTH acts as DEPTH.
module ring_deque_batch_queue #(
	parameter int DEPTH        = 256,
	parameter int MESSAGE_BITS = 32,
	parameter int MAX_PULL     = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rdq_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Command side
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  command,
	input  logic                        batch_first,
	input  logic [rdq_pkg::CNT_W-1:0]   batch_count,
	input  logic [MESSAGE_BITS-1:0]     message_in,
	// Result side
	output logic                        empty,
	input  logic                        pop,
	output logic [2:0]                  status,
	output logic [MESSAGE_BITS-1:0]     message_out,
	output logic                        last,
	output logic [rdq_pkg::FILL_W-1:0]  fill_level
);
	import rdq_pkg::*;

	localparam int DCAP_INT = (DEPTH > 511) ? 511 : DEPTH;

	logic [FILL_W-1:0]       depth_q;
	logic                    reg_sel;
	logic                    cfg_we;
	logic                    cmd_valid;
	logic                    cmd_pop;
	cmd_item_t               cmd;
	logic [MESSAGE_BITS-1:0] cmd_msg;
	logic [RQ_LW-1:0]        rq_level;
	logic                    res_valid;
	res_t                    res;
	logic [MESSAGE_BITS-1:0] res_msg;
	res_t                    out_res;

	// Register decode: the word index sits above the byte offset.
	assign reg_sel = (paddr[2] == REG_DEPTH_IN_USE);
	assign cfg_we  = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? 32'(depth_q) : '0;

	// Hold the depth; reset to DEPTH, capped at what the 9-bit register holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= FILL_W'(DCAP_INT);
		end else if (cfg_we) begin
			depth_q <= pwdata[FILL_W-1:0];
		end
	end

	// Front end: accept and classify each transfer, park it in the command queue.
	rdq_front #(
		.MESSAGE_BITS (MESSAGE_BITS),
		.MAX_PULL     (MAX_PULL)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.batch_first (batch_first),
		.batch_count (batch_count),
		.message_in  (message_in),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.cmd         (cmd),
		.cmd_msg     (cmd_msg)
	);

	// Back end: ring state, slot RAM, pull sequencer; a depth write drops all state.
	rdq_back #(
		.DEPTH        (DEPTH),
		.MESSAGE_BITS (MESSAGE_BITS),
		.MAX_PULL     (MAX_PULL)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_clear    (cfg_we),
		.depth_in_use (depth_q),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.cmd_msg      (cmd_msg),
		.rq_level     (rq_level),
		.res_valid    (res_valid),
		.res          (res),
		.res_msg      (res_msg)
	);

	// Result queue: hold finished results until the consumer takes the transfer.
	rdq_result_q #(
		.MESSAGE_BITS (MESSAGE_BITS)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_res (res),
		.wr_msg (res_msg),
		.pop    (pop),
		.empty  (empty),
		.rd_res (out_res),
		.rd_msg (message_out),
		.level  (rq_level)
	);

	assign status     = out_res.status;
	assign last       = out_res.last;
	assign fill_level = out_res.fill;

`ifndef NO_ASSERTIONS
	// An empty pull reports an empty queue and ends its run.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_EMPTY) |-> (fill_level == '0 && last))
		else $error("empty-queue result with nonzero fill or without last");

	// A clear leaves nothing behind and ends its run.
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_CLEARED) |-> (fill_level == '0 && last))
		else $error("clear result with nonzero fill or without last");

	// Only message results carry a word.
	a_quiet_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_MSG) |-> (message_out == '0))
		else $error("non-message result carries a message word");

	// Every push result, accepted or rejected, closes its run.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_ACCEPT || status == ST_REJECT)) |-> last)
		else $error("push result without last");
`endif

endmodule

// ===== design/rdq_ram.sv =====
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rdq_front.sv =====
module rdq_front #(
	parameter int MESSAGE_BITS = 32,
	parameter int MAX_PULL     = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               command,
	input  logic                     batch_first,
	input  logic [rdq_pkg::CNT_W-1:0] batch_count,
	input  logic [MESSAGE_BITS-1:0]  message_in,
	output logic                     cmd_valid,
	input  logic                     cmd_pop,
	output rdq_pkg::cmd_item_t       cmd,
	output logic [MESSAGE_BITS-1:0]  cmd_msg
);
	import rdq_pkg::*;

	cmd_item_t         item;
	cmd_item_t         cmd_q [CQ_DEPTH];
	logic [MESSAGE_BITS-1:0] msg_q [CQ_DEPTH];
	logic [CQ_PW-1:0]  wr_ptr_q;
	logic [CQ_PW-1:0]  rd_ptr_q;
	logic [CQ_LW-1:0]  level_q;
	logic              do_push;
	logic              do_pop;

	// Classify: saturate pull requests here so the back end sees a small count.
	always_comb begin
		item.op    = cmd_t'(command);
		item.first = batch_first;
		item.count = batch_count;
		if (item.op == CMD_PULL && batch_count > CNT_W'(MAX_PULL)) begin
			item.count = CNT_W'(MAX_PULL);
		end
	end

	assign full      = (level_q == CQ_LW'(CQ_DEPTH));
	assign cmd_valid = (level_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = cmd_q[rd_ptr_q];
	assign cmd_msg   = msg_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q] <= item;
			msg_q[wr_ptr_q] <= message_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/rdq_result_q.sv =====
module rdq_result_q #(
	parameter int MESSAGE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  rdq_pkg::res_t                 wr_res,
	input  logic [MESSAGE_BITS-1:0]       wr_msg,
	input  logic                          pop,
	output logic                          empty,
	output rdq_pkg::res_t                 rd_res,
	output logic [MESSAGE_BITS-1:0]       rd_msg,
	output logic [rdq_pkg::RQ_LW-1:0]     level
);
	import rdq_pkg::*;

	res_t                    res_q [RQ_DEPTH];
	logic [MESSAGE_BITS-1:0] msg_q [RQ_DEPTH];
	logic [RQ_PW-1:0]        wr_ptr_q;
	logic [RQ_PW-1:0]        rd_ptr_q;
	logic [RQ_LW-1:0]        level_q;
	logic                    do_pop;

	// The back end never writes without room, so no full check here.
	assign empty  = (level_q == '0);
	assign do_pop = pop && !empty;
	assign rd_res = res_q[rd_ptr_q];
	assign rd_msg = msg_q[rd_ptr_q];
	assign level  = level_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			res_q[wr_ptr_q] <= wr_res;
			msg_q[wr_ptr_q] <= wr_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/rdq_back.sv =====
module rdq_back #(
	parameter int DEPTH        = 256,
	parameter int MESSAGE_BITS = 32,
	parameter int MAX_PULL     = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_clear,
	input  logic [rdq_pkg::FILL_W-1:0] depth_in_use,
	input  logic                       cmd_valid,
	output logic                       cmd_pop,
	input  rdq_pkg::cmd_item_t         cmd,
	input  logic [MESSAGE_BITS-1:0]    cmd_msg,
	input  logic [rdq_pkg::RQ_LW-1:0]  rq_level,
	output logic                       res_valid,
	output rdq_pkg::res_t              res,
	output logic [MESSAGE_BITS-1:0]    res_msg
);
	import rdq_pkg::*;

	localparam int IW       = $clog2(DEPTH);
	localparam int CW       = ((IW > FILL_W) ? IW : FILL_W) + 1;
	localparam int DCAP_INT = (DEPTH > 511) ? 511 : DEPTH;
	localparam logic [FILL_W-1:0] DCAP = FILL_W'(DCAP_INT);
	localparam int RW       = $clog2(MAX_PULL + 1);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_PULL = 2'b10
	} bk_state_t;

	bk_state_t         state_q, state_n;
	logic [IW-1:0]     front_q, front_n;
	logic [IW-1:0]     back_q, back_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic              acc_q, acc_n;
	logic [CNT_W-1:0]  left_q, left_n;
	logic [RW-1:0]     rem_q, rem_n;
	logic              valid_s1;
	res_t              res_s1;

	logic [FILL_W-1:0] d_eff;
	logic              room;
	logic              launch;
	res_t              launch_res;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic              ram_re;
	logic [MESSAGE_BITS-1:0] ram_rdata;
	logic              acc_tmp;
	logic [CNT_W-1:0]  left_tmp;
	logic              store;
	logic [FILL_W-1:0] take_n;

	function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
			input logic [FILL_W-1:0] d);
		logic [CW-1:0] iw;
		logic [CW-1:0] dw;
		iw = CW'(i);
		dw = CW'(d);
		if (iw == '0 || iw >= dw) begin
			return IW'(dw - 1'b1);
		end
		return IW'(iw - 1'b1);
	endfunction

	function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i,
			input logic [FILL_W-1:0] d);
		logic [CW-1:0] nx;
		nx = CW'(i) + 1'b1;
		if (nx >= CW'(d)) begin
			return '0;
		end
		return IW'(nx);
	endfunction

	// Clamp the configured depth into one to the ring size.
	always_comb begin
		d_eff = depth_in_use;
		if (depth_in_use == '0) begin
			d_eff = FILL_W'(1);
		end else if (depth_in_use > DCAP) begin
			d_eff = DCAP;
		end
	end

	// Count the result in flight through the read stage as taken.
	assign room = ((4'(rq_level) + 4'(valid_s1)) < 4'(RQ_DEPTH));

	assign take_n = (cmd.count < fill_q) ? cmd.count : fill_q;

	always_comb begin
		state_n    = state_q;
		front_n    = front_q;
		back_n     = back_q;
		fill_n     = fill_q;
		acc_n      = acc_q;
		left_n     = left_q;
		rem_n      = rem_q;
		cmd_pop    = 1'b0;
		launch     = 1'b0;
		launch_res = '{status: ST_REJECT, last: 1'b1, fill: fill_q};
		ram_we     = 1'b0;
		ram_waddr  = back_q;
		ram_re     = 1'b0;
		acc_tmp    = acc_q;
		left_tmp   = left_q;
		store      = 1'b0;

		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && room) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						CMD_CLEAR: begin
							front_n    = '0;
							back_n     = '0;
							fill_n     = '0;
							acc_n      = 1'b0;
							left_n     = '0;
							launch     = 1'b1;
							launch_res = '{status: ST_CLEARED, last: 1'b1, fill: '0};
						end
						CMD_PULL: begin
							if (fill_q == '0) begin
								launch     = 1'b1;
								launch_res = '{status: ST_EMPTY, last: 1'b1, fill: '0};
							end else if (take_n != '0) begin
								rem_n   = RW'(take_n);
								state_n = BK_PULL;
							end
						end
						CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
							if (cmd.first) begin
								if (cmd.count <= d_eff - fill_q) begin
									acc_tmp  = 1'b1;
									left_tmp = cmd.count;
								end else begin
									acc_tmp  = 1'b0;
									left_tmp = '0;
								end
							end
							store = acc_tmp && (left_tmp != '0) && (fill_q < d_eff);
							if (store) begin
								ram_we = 1'b1;
								if (cmd.op == CMD_PUSH_BACK) begin
									ram_waddr = back_q;
									back_n    = step_down(back_q, d_eff);
								end else begin
									ram_waddr = step_up(front_q, d_eff);
									front_n   = step_up(front_q, d_eff);
								end
								fill_n   = fill_q + 1'b1;
								left_tmp = left_tmp - 1'b1;
								if (left_tmp == '0) begin
									acc_tmp = 1'b0;
								end
							end
							acc_n      = acc_tmp;
							left_n     = left_tmp;
							launch     = 1'b1;
							launch_res = '{status: status_t'(store ? ST_ACCEPT : ST_REJECT),
								last: 1'b1, fill: fill_n};
						end
						default: begin
						end
					endcase
				end
			end
			BK_PULL: begin
				if (room) begin
					ram_re     = 1'b1;
					front_n    = step_down(front_q, d_eff);
					fill_n     = fill_q - 1'b1;
					rem_n      = rem_q - 1'b1;
					launch     = 1'b1;
					launch_res = '{status: ST_MSG, last: (rem_q == RW'(1)),
						fill: fill_q - 1'b1};
					if (rem_q == RW'(1)) begin
						state_n = BK_IDLE;
					end
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase

		if (cfg_clear) begin
			state_n = BK_IDLE;
			front_n = '0;
			back_n  = '0;
			fill_n  = '0;
			acc_n   = 1'b0;
			left_n  = '0;
		end
	end

	rdq_ram #(
		.WIDTH (MESSAGE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd_msg),
		.re    (ram_re),
		.raddr (front_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (launch) begin
			res_s1 <= launch_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			front_q  <= '0;
			back_q   <= '0;
			fill_q   <= '0;
			acc_q    <= 1'b0;
			left_q   <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_n;
			front_q  <= front_n;
			back_q   <= back_n;
			fill_q   <= fill_n;
			acc_q    <= acc_n;
			left_q   <= left_n;
			rem_q    <= rem_n;
			valid_s1 <= launch;
		end
	end

	assign res_valid = valid_s1;
	assign res       = res_s1;
	assign res_msg   = (res_s1.status == ST_MSG) ? ram_rdata : '0;

endmodule

// ===== sim/ring_deque_batch_queue_checker.sv =====
module ring_deque_batch_queue_checker #(
	parameter int DEPTH        = 256,
	parameter int MESSAGE_BITS = 32,
	parameter int MAX_PULL     = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rdq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic [31:0]                prdata,
	input  logic                       pready,
	input  logic                       push,
	input  logic                       full,
	input  logic [1:0]                 command,
	input  logic                       batch_first,
	input  logic [rdq_pkg::CNT_W-1:0]  batch_count,
	input  logic [MESSAGE_BITS-1:0]    message_in,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [2:0]                 status,
	input  logic [MESSAGE_BITS-1:0]    message_out,
	input  logic                       last,
	input  logic [rdq_pkg::FILL_W-1:0] fill_level,
	output int                         fail_count,
	output int                         outstanding,
	output int                         checked_results
);
	import rdq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CFG_W = 9;

	typedef struct packed {
		status_t                 st;
		logic [MESSAGE_BITS-1:0] word;
		logic                    fin;
		logic [FILL_W-1:0]       lvl;
	} result_t;

	result_t                 due_results[$];
	logic [MESSAGE_BITS-1:0] ring_words[DEPTH];
	logic [IDX_W-1:0]        head_slot;
	logic [IDX_W-1:0]        tail_slot;
	logic [FILL_W-1:0]       held;
	logic                    batch_open;
	logic [CNT_W-1:0]        batch_rem;
	logic [CFG_W-1:0]        depth_reg;
	int                      errors;
	int                      pending;
	int                      checked;

	assign fail_count      = errors;
	assign outstanding     = pending;
	assign checked_results = checked;

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	function automatic int unsigned live_depth();
		int unsigned d;
		d = depth_reg;
		if (d == 0) d = 1;
		if (d > DEPTH) d = DEPTH;
		return d;
	endfunction

	function automatic int unsigned ring_down(int unsigned i, int unsigned d);
		return (i == 0 || i >= d) ? d - 1 : i - 1;
	endfunction

	function automatic int unsigned ring_up(int unsigned i, int unsigned d);
		return (i + 1 >= d) ? 0 : i + 1;
	endfunction

	task automatic empty_ring();
		head_slot  = '0;
		tail_slot  = '0;
		held       = '0;
		batch_open = 1'b0;
		batch_rem  = '0;
	endtask

	task automatic queue_result(status_t st, logic [MESSAGE_BITS-1:0] w, logic fin);
		result_t r;
		r.st   = st;
		r.word = w;
		r.fin  = fin;
		r.lvl  = held;
		due_results.push_back(r);
	endtask

	// Advance the ring by one command and queue the results it owes.
	task automatic model_command(cmd_t c, logic f, logic [CNT_W-1:0] n,
			logic [MESSAGE_BITS-1:0] m);
		int unsigned             d;
		int unsigned             take;
		int unsigned             k;
		logic [MESSAGE_BITS-1:0] w;
		d = live_depth();
		case (c)
			CMD_CLEAR: begin
				empty_ring();
				queue_result(ST_CLEARED, '0, 1'b1);
			end
			CMD_PULL: begin
				take = (n > MAX_PULL) ? MAX_PULL : n;
				if (held == 0) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					if (take > held) take = held;
					for (k = 0; k < take; k++) begin
						w         = ring_words[head_slot];
						head_slot = IDX_W'(ring_down(head_slot, d));
						held      = held - 1'b1;
						queue_result(ST_MSG, w, k + 1 == take);
					end
				end
			end
			default: begin
				if (f) begin
					if (n <= d - held) begin
						batch_open = 1'b1;
						batch_rem  = n;
					end else begin
						batch_open = 1'b0;
						batch_rem  = '0;
					end
				end
				if (batch_open && batch_rem != 0 && held < d) begin
					if (c == CMD_PUSH_BACK) begin
						ring_words[tail_slot] = m;
						tail_slot = IDX_W'(ring_down(tail_slot, d));
					end else begin
						head_slot = IDX_W'(ring_up(head_slot, d));
						ring_words[head_slot] = m;
					end
					held      = held + 1'b1;
					batch_rem = batch_rem - 1'b1;
					if (batch_rem == 0) batch_open = 1'b0;
					queue_result(ST_ACCEPT, '0, 1'b1);
				end else begin
					queue_result(ST_REJECT, '0, 1'b1);
				end
			end
		endcase
	endtask

	task automatic check_result();
		result_t want;
		checked++;
		if (due_results.size() == 0) begin
			errors++;
			$display("%0t: result with none expected: status %0d message %h last %0b fill %0d",
				$time, status, message_out, last, fill_level);
		end else begin
			want = due_results.pop_front();
			if (status !== want.st) begin
				errors++;
				$display("%0t: status expected %0d, got %0d", $time, want.st, status);
			end
			if (message_out !== want.word) begin
				errors++;
				$display("%0t: message_out expected %h, got %h", $time, want.word, message_out);
			end
			if (last !== want.fin) begin
				errors++;
				$display("%0t: last expected %0b, got %0b", $time, want.fin, last);
			end
			if (fill_level !== want.lvl) begin
				errors++;
				$display("%0t: fill_level expected %0d, got %0d", $time, want.lvl, fill_level);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_reg = CFG_W'(DEPTH);
			empty_ring();
			due_results.delete();
			pending = 0;
		end else begin
			// Results leave before new commands land: the block never answers in the same cycle.
			if (pop && !empty) check_result();
			if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_DEPTH_IN_USE) begin
				if (pwrite) begin
					depth_reg = pwdata[CFG_W-1:0];
					empty_ring();
				end else if (prdata !== 32'(depth_reg)) begin
					errors++;
					$display("%0t: depth_in_use read expected %0d, got %0d",
						$time, depth_reg, prdata);
				end
			end
			if (push && !full)
				model_command(cmd_t'(command), batch_first, batch_count, message_in);
			pending = due_results.size();
		end
	end

endmodule

// ===== sim/ring_deque_batch_queue_tb.sv =====
module ring_deque_batch_queue_tb;
	import rdq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 11;
	// Longest stretch with no transfer on any port before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles to let a pull of zero (which owes no result) drain out of the pipe.
	localparam int QUIET_CYCLES = 24;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 57;

	localparam logic [ADDR_W-1:0] DEPTH_ADDR  = {REG_DEPTH_IN_USE, 2'b00};
	localparam logic [ADDR_W-1:0] NO_REG_ADDR = {~REG_DEPTH_IN_USE, 2'b00};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              push;
	logic              full;
	logic [1:0]        command;
	logic              batch_first;
	logic [CNT_W-1:0]  batch_count;
	logic [31:0]       message_in;
	logic              empty;
	logic              pop;
	logic [2:0]        status;
	logic [31:0]       message_out;
	logic              last;
	logic [FILL_W-1:0] fill_level;

	int          fail_count;
	int          outstanding;
	int          checked_results;
	int          send_idle;
	int          recv_stall;
	int          items_sent;
	int          depth_writes;
	int unsigned cur_depth;
	int          quiet_run;

	ring_deque_batch_queue u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.command     (command),
		.batch_first (batch_first),
		.batch_count (batch_count),
		.message_in  (message_in),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.message_out (message_out),
		.last        (last),
		.fill_level  (fill_level)
	);

	ring_deque_batch_queue_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.push            (push),
		.full            (full),
		.command         (command),
		.batch_first     (batch_first),
		.batch_count     (batch_count),
		.message_in      (message_in),
		.empty           (empty),
		.pop             (pop),
		.status          (status),
		.message_out     (message_out),
		.last            (last),
		.fill_level      (fill_level),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.checked_results (checked_results)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Result side: decide pop afresh at every falling edge, stalling recv_stall percent
	// of the cycles; hold pop low while reset is asserted.
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= recv_stall);
	end

	// Watchdog: count cycles in which no port completes a transfer.
	initial begin
		quiet_run = 0;
		while (quiet_run < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable))
				quiet_run = 0;
			else
				quiet_run++;
		end
		$display("%0t: no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
		$display("[ring_deque_batch_queue] ERROR");
		$finish;
	end

	function automatic cmd_t rand_dir();
		return ($urandom_range(0, 1) == 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
	endfunction

	function automatic logic rand_bit();
		return $urandom_range(0, 1) == 1;
	endfunction

	// Mostly modest pulls; now and then zero, exactly the cap, or beyond it up to 256.
	function automatic int unsigned pull_count();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) return $urandom_range(1, 12);
		if (r == 7) return 0;
		if (r == 8) return 64;
		return $urandom_range(65, 256);
	endfunction

	// Present one command at the falling edge and hold it until the block takes it.
	// Enter and leave just after a falling edge.
	task automatic send_item(cmd_t c, logic f, int unsigned n, logic [31:0] m);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push        <= 1'b1;
		command     <= c;
		batch_first <= f;
		batch_count <= CNT_W'(n);
		message_in  <= m;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Send the first item carrying count n, then sent_n - 1 followers. Followers carry a
	// random count, which the block must ignore. Mixed batches pick a side per item.
	task automatic send_batch(cmd_t dir, int unsigned n, int unsigned sent_n, bit mixed);
		int unsigned k;
		for (k = 0; k < sent_n; k++)
			send_item(mixed ? rand_dir() : dir, k == 0,
				(k == 0) ? n : $urandom_range(0, 256), $urandom);
	endtask

	// Drop push, wait until every owed result has been popped, then let the pipe settle.
	task automatic drain();
		push <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	// A setup phase, then an access phase, then the port is released.
	task automatic reg_access(logic wr, logic [ADDR_W-1:0] a, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_depth(int unsigned d);
		drain();
		reg_access(1'b1, DEPTH_ADDR, d);
		reg_access(1'b0, DEPTH_ADDR, 32'd0);
		cur_depth = d;
		depth_writes++;
	endtask

	// Random traffic: mostly well-formed batches with random content, plus pulls, clears
	// and a share of broken sequences.
	task automatic run_phase(int n_items);
		int          start;
		int unsigned pick;
		int unsigned n;
		int unsigned cap;
		int unsigned low;
		start = items_sent;
		while (items_sent - start < n_items) begin
			pick = $urandom_range(0, 99);
			cap  = (cur_depth < 8) ? cur_depth : 8;
			if (pick < 55) begin
				n = $urandom_range(1, cap);
				if ($urandom_range(0, 19) == 0 && cur_depth <= 16) n = cur_depth;
				send_batch(rand_dir(), n, n, $urandom_range(0, 4) == 0);
			end else if (pick < 80) begin
				send_item(CMD_PULL, rand_bit(), pull_count(), $urandom);
			end else if (pick < 85) begin
				send_item(CMD_CLEAR, rand_bit(), $urandom_range(0, 256), $urandom);
			end else begin
				case ($urandom_range(0, 3))
					// follower with no batch open
					0: send_item(rand_dir(), 1'b0, $urandom_range(0, 256), $urandom);
					// batch of zero
					1: send_batch(rand_dir(), 0, 1, 1'b0);
					// batch larger than the ring
					2: begin
						low = (cur_depth < 256) ? cur_depth + 1 : 256;
						send_batch(rand_dir(), $urandom_range(low, 256),
							$urandom_range(1, 3), 1'b1);
					end
					// batch cut short by whatever comes next
					default: begin
						n = $urandom_range(2, 8);
						send_batch(rand_dir(), n, $urandom_range(1, n - 1), 1'b0);
					end
				endcase
			end
		end
	endtask

	initial begin
		int p;
		int unsigned d;
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		push         = 1'b0;
		command      = CMD_PUSH_BACK;
		batch_first  = 1'b0;
		batch_count  = '0;
		message_in   = '0;
		pop          = 1'b0;
		send_idle    = 0;
		recv_stall   = 0;
		items_sent   = 0;
		depth_writes = 0;
		cur_depth    = 256;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset depth, no idling on either side.
		send_item(CMD_PULL, 1'b0, 5, 32'h0);                 // pull from an empty queue
		send_item(CMD_PUSH_BACK, 1'b1, 3, 32'h0000_0000);    // back batch of three
		send_item(CMD_PUSH_BACK, 1'b0, 0, 32'hFFFF_FFFF);
		send_item(CMD_PUSH_BACK, 1'b0, 256, $urandom);
		send_item(CMD_PUSH_FRONT, 1'b1, 2, 32'hA5A5_5A5A);   // front batch, mixed sides
		send_item(CMD_PUSH_BACK, 1'b0, 7, $urandom);
		send_item(CMD_PULL, 1'b1, 256, $urandom);            // saturating pull, cut at fill
		send_item(CMD_PUSH_BACK, 1'b1, 0, $urandom);         // batch of zero
		send_item(CMD_PUSH_FRONT, 1'b0, 1, $urandom);        // follower, nothing reserved
		send_item(CMD_PUSH_BACK, 1'b1, 1, $urandom);
		send_item(CMD_PULL, 1'b0, 0, $urandom);              // zero pull, owes nothing
		send_item(CMD_PUSH_FRONT, 1'b1, 4, $urandom);        // abandoned by the next batch
		send_item(CMD_PUSH_FRONT, 1'b0, 0, $urandom);
		send_item(CMD_PUSH_BACK, 1'b1, 1, $urandom);
		send_item(CMD_PUSH_BACK, 1'b0, 0, $urandom);
		send_item(CMD_PUSH_BACK, 1'b1, 256, $urandom);       // too big for the free room
		send_item(CMD_CLEAR, 1'b1, 256, $urandom);
		send_item(CMD_PULL, 1'b1, 1, $urandom);
		send_item(CMD_PUSH_BACK, 1'b1, 256, $urandom);       // whole ring reserved
		send_item(CMD_PUSH_FRONT, 1'b0, 3, $urandom);
		send_item(CMD_PULL, 1'b0, 64, $urandom);

		// Smallest ring: one slot.
		set_depth(1);
		send_item(CMD_PUSH_BACK, 1'b1, 2, $urandom);
		send_item(CMD_PUSH_FRONT, 1'b1, 1, $urandom);
		send_item(CMD_PUSH_BACK, 1'b1, 1, $urandom);         // ring full
		send_item(CMD_PULL, 1'b0, 3, $urandom);

		// Random phases: cycle through the four idle patterns and several depths.
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: d = 256;
				1: d = 1;
				2: d = 2;
				3: d = $urandom_range(3, 40);
				4: d = 255;
				5: d = 7;
				6: d = $urandom_range(3, 254);
				default: d = 256;
			endcase
			set_depth(d);
			if (p == 3) begin
				// A write to an address with no register must leave the depth alone.
				reg_access(1'b1, NO_REG_ADDR, $urandom);
				reg_access(1'b0, DEPTH_ADDR, 32'd0);
			end
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 45; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 45; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			run_phase(PHASE_ITEMS);
		end

		drain();

		$display("Covered %0d commands and %0d checked results over %0d depth settings,",
			items_sent, checked_results, depth_writes);
		$display("with mixed batches, broken batches, capped and empty pulls, clears and idling.");
		if (fail_count == 0)
			$display("[ring_deque_batch_queue] OK");
		else
			$display("[ring_deque_batch_queue] ERROR");
		$finish;
	end

endmodule
